@@ src/rbm_pkg.sv @@
package rbm_pkg;

  localparam int unsigned IDX_W      = 5;
  localparam int unsigned ROW_OUT_W  = 32;
  localparam int unsigned IN_TDATA_W = 16;
  localparam int unsigned IN_TUSER_W = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_JOIN   = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] target;
    logic [IDX_W-1:0] source;
  } op_t;

  typedef struct packed {
    logic                 hit;
    logic [ROW_OUT_W-1:0] row_bits;
  } res_t;

endpackage

@@ src/rbm_matrix.sv @@
module rbm_matrix #(
  parameter int unsigned NUM_CLOCKS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  rbm_pkg::op_t  op,
  output rbm_pkg::res_t res
);

  localparam int unsigned ROW_IDX_W = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
  localparam int unsigned EXT_W     = ROW_IDX_W + rbm_pkg::IDX_W;

  logic [NUM_CLOCKS-1:0] rows      [NUM_CLOCKS];
  logic [NUM_CLOCKS-1:0] rows_next [NUM_CLOCKS];

  logic [EXT_W-1:0]      tgt_ext;
  logic [EXT_W-1:0]      src_ext;
  logic [ROW_IDX_W-1:0]  tgt_idx;
  logic [ROW_IDX_W-1:0]  src_idx;
  logic                  tgt_ok;
  logic                  src_ok;
  logic [NUM_CLOCKS-1:0] tgt_row;
  logic [NUM_CLOCKS-1:0] src_row;
  logic                  do_join;
  logic [NUM_CLOCKS+rbm_pkg::ROW_OUT_W-1:0] row_ext;

  assign tgt_ext = {{ROW_IDX_W{1'b0}}, op.target};
  assign src_ext = {{ROW_IDX_W{1'b0}}, op.source};
  assign tgt_idx = tgt_ext[ROW_IDX_W-1:0];
  assign src_idx = src_ext[ROW_IDX_W-1:0];
  assign tgt_ok  = ({27'd0, op.target} < 32'(NUM_CLOCKS));
  assign src_ok  = ({27'd0, op.source} < 32'(NUM_CLOCKS));
  assign tgt_row = rows[tgt_idx];
  assign src_row = rows[src_idx];

  // join is a no-op when target already holds the source clock
  assign do_join = tgt_ok && src_ok && !tgt_row[src_idx];

  always_comb begin
    for (int r = 0; r < NUM_CLOCKS; r++) begin
      rows_next[r] = rows[r];
    end
    unique case (op.func)
      rbm_pkg::FUNC_CLEAR: begin
        for (int r = 0; r < NUM_CLOCKS; r++) begin
          rows_next[r] = '0;
        end
      end
      rbm_pkg::FUNC_CREATE: begin
        if (tgt_ok) begin
          rows_next[tgt_idx] = NUM_CLOCKS'(1) << tgt_idx;
        end
      end
      rbm_pkg::FUNC_JOIN: begin
        // every row that already reaches the target picks up the source row
        if (do_join) begin
          for (int r = 0; r < NUM_CLOCKS; r++) begin
            if ((ROW_IDX_W'(r) == tgt_idx) || rows[r][tgt_idx]) begin
              rows_next[r] = rows[r] | src_row;
            end
          end
        end
      end
      rbm_pkg::FUNC_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    row_ext = '0;
    if (tgt_ok && (op.func != rbm_pkg::FUNC_CLEAR)) begin
      row_ext = {{rbm_pkg::ROW_OUT_W{1'b0}}, rows_next[tgt_idx]};
    end
    res.row_bits = row_ext[rbm_pkg::ROW_OUT_W-1:0];
    res.hit      = (op.func == rbm_pkg::FUNC_QUERY) && tgt_ok && src_ok && tgt_row[src_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_CLOCKS; r++) begin
        rows[r] <= '0;
      end
    end else if (en) begin
      for (int r = 0; r < NUM_CLOCKS; r++) begin
        rows[r] <= rows_next[r];
      end
    end
  end

endmodule

@@ src/reachability_bit_matrix_top.sv @@
// Reachability bit matrix: NUM_CLOCKS rows of NUM_CLOCKS flops hold which clocks each
// clock has absorbed, kept transitively closed on every join. One request (create,
// join, query or clear, selected by s_tuser) is taken per cycle and yields exactly one
// result carrying the target row after the operation and, for a query, the hit bit.
// An accepted request sits in the input register while the all-rows update is computed
// and lands in the result register that drives m_tdata once the result side advances.
// The matrix update is a single parallel step, so throughput is one request per cycle
// whenever the result side keeps taking; a stalled result holds the input register, so
// at most two requests are in flight. The matrix is cleared by reset.
module reachability_bit_matrix_top #(
  parameter int unsigned NUM_CLOCKS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [4:0] target, [9:5] source, [15:10] zero
  input  logic [rbm_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [rbm_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] hit, [32:1] row_bits, [39:33] zero
  output logic [rbm_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic          in_valid;
  rbm_pkg::op_t  in_op;
  logic          out_valid;
  rbm_pkg::res_t out_res;
  rbm_pkg::res_t res;
  logic          advance;
  logic          fire;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_op.func   <= rbm_pkg::func_t'(s_tuser);
      in_op.target <= s_tdata[rbm_pkg::IDX_W-1:0];
      in_op.source <= s_tdata[2*rbm_pkg::IDX_W-1:rbm_pkg::IDX_W];
    end
  end

  rbm_matrix #(
    .NUM_CLOCKS(NUM_CLOCKS)
  ) u_matrix (
    .clk (clk),
    .rst (rst),
    .en  (fire),
    .op  (in_op),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.row_bits, out_res.hit};

endmodule

@@ src/rbm_checker.sv @@
module rbm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rbm_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input side only backs up when the result side is stalled
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("request refused while result path free");

  // a hit means the returned row holds at least one set bit
  a_hit_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[32:1] != 32'd0)
    else $error("hit with empty row");

endmodule

bind reachability_bit_matrix_top rbm_checker u_rbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
